FILE: rtl/core/vcec_pkg.sv
package vcec_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned FRAME_W    = 19;
  localparam int unsigned INDEX_W    = 18;
  localparam int unsigned SILENCE_W  = 16;
  localparam int unsigned MAX_MS_W   = 20;
  localparam int unsigned CHUNK_W    = 8;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 64;

  // Frame count field limit and default store depth
  localparam int unsigned FRAME_FIELD_MAX   = 524287;
  localparam int unsigned STORE_DEPTH_DEF   = 262144;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CAPTURE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES  = 3'd5;

  // Register reset values
  localparam logic                 WAKE_ENABLE_RST = 1'b1;
  localparam logic [SILENCE_W-1:0] SILENCE_LIM_RST = 16'd1200;
  localparam logic [MAX_MS_W-1:0]  MAX_CAPTURE_RST = 20'd10000;
  localparam logic [FRAME_W-1:0]   MIN_FRAMES_RST  = 19'd1600;
  localparam logic [CHUNK_W-1:0]   CHUNK_MS_RST    = 8'd32;
  localparam logic [FRAME_W-1:0]   MAX_FRAMES_RST  = 19'd160000;

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_DETECT    = 2'd1,
    OP_PTT_START = 2'd2,
    OP_PTT_STOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PTT  = 2'd1,
    MODE_WAKE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_SILENCE = 2'd1,
    CAUSE_MAX     = 2'd2,
    CAUSE_PTT     = 2'd3
  } cause_t;

  typedef struct packed {
    logic                 wake_enable;
    logic [SILENCE_W-1:0] silence_limit_ms;
    logic [MAX_MS_W-1:0]  max_capture_ms;
    logic [FRAME_W-1:0]   min_frames;
    logic [CHUNK_W-1:0]   chunk_ms;
    logic [FRAME_W-1:0]   max_frames;
  } cfg_t;

  typedef struct packed {
    op_t                        operation;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       wake_detected;
    logic                       vad_silent;
    logic [TIME_W-1:0]          now_ms;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mono_sample;
    logic                       store_valid;
    logic [INDEX_W-1:0]         store_index;
    logic                       wake_event;
    logic                       accepted;
    logic                       capture_done;
    cause_t                     done_cause;
    logic [FRAME_W-1:0]         captured_frames;
    logic                       capture_kept;
    mode_t                      mode_now;
  } result_t;

  // (L+R)/2 truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] mix_mono(
    input logic signed [SAMPLE_W-1:0] l,
    input logic signed [SAMPLE_W-1:0] r
  );
    logic signed [SAMPLE_W:0] sum;
    logic signed [SAMPLE_W:0] adj;
    sum = {l[SAMPLE_W-1], l} + {r[SAMPLE_W-1], r};
    adj = sum + {{SAMPLE_W{1'b0}}, (sum[SAMPLE_W] & sum[0])};
    return adj[SAMPLE_W:1];
  endfunction

endpackage

FILE: rtl/core/vcec_cfg_regs.sv
module vcec_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vcec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vcec_pkg::CFG_DATA_W-1:0]     cfg_data,
  output vcec_pkg::cfg_t                      cfg
);
  import vcec_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wake_enable      <= WAKE_ENABLE_RST;
      cfg.silence_limit_ms <= SILENCE_LIM_RST;
      cfg.max_capture_ms   <= MAX_CAPTURE_RST;
      cfg.min_frames       <= MIN_FRAMES_RST;
      cfg.chunk_ms         <= CHUNK_MS_RST;
      cfg.max_frames       <= MAX_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAKE_ENABLE: cfg.wake_enable      <= cfg_data[0];
        REG_SILENCE_LIM: cfg.silence_limit_ms <= cfg_data[SILENCE_W-1:0];
        REG_MAX_CAPTURE: cfg.max_capture_ms   <= cfg_data[MAX_MS_W-1:0];
        REG_MIN_FRAMES:  cfg.min_frames       <= cfg_data[FRAME_W-1:0];
        REG_CHUNK_MS:    cfg.chunk_ms         <= cfg_data[CHUNK_W-1:0];
        REG_MAX_FRAMES:  cfg.max_frames       <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/vcec_capture_ctrl.sv
module vcec_capture_ctrl #(
  parameter int unsigned STORE_DEPTH = vcec_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  vcec_pkg::item_t    item,
  input  vcec_pkg::cfg_t     cfg,
  output vcec_pkg::result_t  result
);
  import vcec_pkg::*;

  localparam int unsigned CAP_LIMIT_I =
    (STORE_DEPTH > FRAME_FIELD_MAX) ? FRAME_FIELD_MAX : STORE_DEPTH;
  localparam logic [FRAME_W-1:0] CAP_LIMIT = CAP_LIMIT_I[FRAME_W-1:0];

  mode_t                capture_mode, capture_mode_next;
  logic [FRAME_W-1:0]   frame_count, frame_count_next;
  logic [SILENCE_W-1:0] silence_ms_count, silence_ms_count_next;
  logic [TIME_W-1:0]    capture_start_time, capture_start_time_next;

  logic [FRAME_W-1:0]   capacity;
  logic                 wake_start;
  mode_t                mode_eff;
  logic [FRAME_W-1:0]   frames_eff;
  logic [SILENCE_W-1:0] silence_eff;
  logic [TIME_W-1:0]    start_eff;
  logic [SILENCE_W:0]   silence_sum;
  logic [SILENCE_W-1:0] silence_upd;
  logic [TIME_W-1:0]    duration;
  logic                 silence_hit;
  logic                 by_max;

  assign capacity = (cfg.max_frames > CAP_LIMIT) ? CAP_LIMIT : cfg.max_frames;

  // a wake detection in idle, with wake enabled, restarts the capture state before the checks
  assign wake_start  = cfg.wake_enable && item.wake_detected && (capture_mode == MODE_IDLE);
  assign mode_eff    = wake_start ? MODE_WAKE : capture_mode;
  assign frames_eff  = wake_start ? '0 : frame_count;
  assign silence_eff = wake_start ? '0 : silence_ms_count;
  assign start_eff   = wake_start ? item.now_ms : capture_start_time;

  assign silence_sum = {1'b0, silence_eff} + {{(SILENCE_W + 1 - CHUNK_W){1'b0}}, cfg.chunk_ms};
  assign silence_upd = !item.vad_silent ? '0 :
                       silence_sum[SILENCE_W] ? {SILENCE_W{1'b1}} : silence_sum[SILENCE_W-1:0];
  assign duration    = item.now_ms - start_eff;
  assign silence_hit = silence_upd >= cfg.silence_limit_ms;
  assign by_max      = duration >= {{(TIME_W - MAX_MS_W){1'b0}}, cfg.max_capture_ms};

  always_comb begin
    capture_mode_next       = capture_mode;
    frame_count_next        = frame_count;
    silence_ms_count_next   = silence_ms_count;
    capture_start_time_next = capture_start_time;

    result                 = '0;
    result.done_cause      = CAUSE_NONE;

    case (item.operation)
      OP_SAMPLE: begin
        result.mono_sample = mix_mono(item.left_sample, item.right_sample);
        if (capture_mode != MODE_IDLE && frame_count < capacity) begin
          result.store_valid = 1'b1;
          result.store_index = frame_count[INDEX_W-1:0];
          frame_count_next   = frame_count + FRAME_W'(1);
        end
      end
      OP_DETECT: begin
        result.wake_event       = wake_start;
        capture_mode_next       = mode_eff;
        frame_count_next        = frames_eff;
        silence_ms_count_next   = silence_eff;
        capture_start_time_next = start_eff;
        if (mode_eff == MODE_WAKE) begin
          silence_ms_count_next = silence_upd;
          if (silence_hit || by_max) begin
            result.capture_done    = 1'b1;
            result.done_cause      = silence_hit ? CAUSE_SILENCE : CAUSE_MAX;
            result.captured_frames = frames_eff;
            result.capture_kept    = frames_eff >= cfg.min_frames;
            capture_mode_next      = MODE_IDLE;
            frame_count_next       = '0;
            silence_ms_count_next  = '0;
          end
        end
      end
      OP_PTT_START: begin
        if (capture_mode == MODE_IDLE) begin
          result.accepted         = 1'b1;
          capture_mode_next       = MODE_PTT;
          frame_count_next        = '0;
          silence_ms_count_next   = '0;
          capture_start_time_next = item.now_ms;
        end
      end
      OP_PTT_STOP: begin
        if (capture_mode == MODE_PTT) begin
          result.accepted        = 1'b1;
          result.capture_done    = 1'b1;
          result.done_cause      = CAUSE_PTT;
          result.captured_frames = frame_count;
          result.capture_kept    = 1'b1;
          capture_mode_next      = MODE_IDLE;
          frame_count_next       = '0;
          silence_ms_count_next  = '0;
        end
      end
      default: ;
    endcase

    result.mode_now = capture_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_mode       <= MODE_IDLE;
      frame_count        <= '0;
      silence_ms_count   <= '0;
      capture_start_time <= '0;
    end else if (advance) begin
      capture_mode       <= capture_mode_next;
      frame_count        <= frame_count_next;
      silence_ms_count   <= silence_ms_count_next;
      capture_start_time <= capture_start_time_next;
    end
  end

endmodule

FILE: rtl/core/voice_capture_endpoint_controller_core.sv
// Speech capture controller core.
// Input stream (s_*): one word per sample, detect result or push-to-talk
// start/stop; tuser carries the operation code. Output stream (m_*): one
// result word per input word, in order: mono mix, store address, wake and
// end-of-capture flags, capture length and the mode after the word.
// Config port: write cfg_data to register cfg_index when cfg_we is high;
// only while no word is in flight.
// Path: input register, then result register. Throughput: one word per
// cycle while m_tready is high; the mode and counter update is
// combinational between the two registers.
// Reset: mode idle, counters and start time cleared, registers at their
// defaults, both stages empty. No clearing pass is needed.
// Stall: a stalled m_tready holds the result; the input stage still takes
// one more word, then s_tready drops until the result is taken.
module voice_capture_endpoint_controller_core #(
  parameter int unsigned STORE_DEPTH = vcec_pkg::STORE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // left_sample[15:0], right_sample[31:16], wake_detected[32],
  // vad_silent[33], now_ms[65:34], zero[71:66]
  input  logic [vcec_pkg::IN_DATA_W-1:0]    s_tdata,
  // operation[1:0]
  input  logic [vcec_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // mono_sample[15:0], store_valid[16], store_index[34:17], wake_event[35],
  // accepted[36], capture_done[37], done_cause[39:38],
  // captured_frames[58:40], capture_kept[59], mode_now[61:60], zero[63:62]
  output logic [vcec_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_we,
  input  logic [vcec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vcec_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vcec_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_full;
  result_t result;
  result_t res_q;
  logic    out_full;
  logic    advance;

  assign advance  = in_full && (!out_full || m_tready);
  assign s_tready = !in_full || advance;

  vcec_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vcec_capture_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .cfg     (cfg),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q.operation     <= op_t'(s_tuser);
      item_q.left_sample   <= s_tdata[15:0];
      item_q.right_sample  <= s_tdata[31:16];
      item_q.wake_detected <= s_tdata[32];
      item_q.vad_silent    <= s_tdata[33];
      item_q.now_ms        <= s_tdata[65:34];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {2'b00,
                     res_q.mode_now,
                     res_q.capture_kept,
                     res_q.captured_frames,
                     res_q.done_cause,
                     res_q.capture_done,
                     res_q.accepted,
                     res_q.wake_event,
                     res_q.store_index,
                     res_q.store_valid,
                     res_q.mono_sample};

endmodule
